/* rtl/tmm_pkg.sv */
// Shared types, constants and helpers for the transposed matrix multiply block.
`timescale 1ns / 1ps

package tmm_pkg;

  localparam int MAX_DIM    = 8;
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int DIM_W      = 4;
  localparam int IDX_W      = $clog2(MAX_DIM);
  localparam int DEPTH      = MAX_DIM * MAX_DIM;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int COUNT_W    = $clog2(2 * DEPTH);
  localparam int TOTAL_W    = COUNT_W + 1;
  localparam int PROD_W     = 2 * DATA_WIDTH;
  localparam int GUARD_W    = $clog2(MAX_DIM) + 1;
  localparam int ACC_W      = PROD_W + GUARD_W;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_M  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_N  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_K = 2'd2;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ISSUE,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic              wr_a;
    logic              wr_b;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd;
    logic [ADDR_W-1:0] rd_a_addr;
    logic [ADDR_W-1:0] rd_b_addr;
    logic              first;
    logic              last_tap;
    logic              emit;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic              last_entry;
  } cmd_t;

  typedef struct packed {
    logic acc_done;
    logic out_free;
  } stat_t;

  // A zero dimension acts as one, and anything above the maximum acts as the maximum.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r);
    logic [DIM_W-1:0] d;
    d = r;
    if (r == '0) begin
      d = DIM_W'(1);
    end else if (r > DIM_W'(MAX_DIM)) begin
      d = DIM_W'(MAX_DIM);
    end
    return d;
  endfunction

endpackage

/* rtl/tmm_ctrl.sv */
// Controller: size registers, load counter and the sequencer for the multiply-accumulate passes.
`timescale 1ns / 1ps

module tmm_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tmm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tmm_pkg::DIM_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tmm_pkg::stat_t                stat,
  output tmm_pkg::cmd_t                 cmd
);
  import tmm_pkg::*;

  state_t             state, state_next;
  logic [DIM_W-1:0]   rows_m, cols_n, inner_k;
  logic [COUNT_W-1:0] load_count, load_count_next;
  logic [IDX_W-1:0]   row, row_next, col, col_next, tap, tap_next;
  logic [ADDR_W-1:0]  a_base, a_base_next, b_base, b_base_next;

  logic [DIM_W-1:0]   m, n, k;
  logic [COUNT_W-1:0] a_len, b_off;
  logic [TOTAL_W-1:0] total;

  assign m     = eff_dim(rows_m);
  assign n     = eff_dim(cols_n);
  assign k     = eff_dim(inner_k);
  assign a_len = COUNT_W'(m) * COUNT_W'(k);
  assign total = TOTAL_W'(a_len) + TOTAL_W'(k) * TOTAL_W'(n);
  assign b_off = load_count - a_len;

  always_comb begin
    state_next      = state;
    load_count_next = load_count;
    row_next        = row;
    col_next        = col;
    tap_next        = tap;
    a_base_next     = a_base;
    b_base_next     = b_base;
    cmd             = '0;
    in_ready        = 1'b0;
    cmd.rd_a_addr   = a_base + ADDR_W'(tap);
    cmd.rd_b_addr   = b_base + ADDR_W'(tap);
    cmd.row         = row;
    cmd.col         = col;
    cmd.last_entry  = (row == IDX_W'(m - 1'b1)) && (col == IDX_W'(n - 1'b1));

    unique case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (load_count < a_len) begin
            cmd.wr_a    = 1'b1;
            cmd.wr_addr = load_count[ADDR_W-1:0];
          end else begin
            cmd.wr_b    = 1'b1;
            cmd.wr_addr = b_off[ADDR_W-1:0];
          end
          if (TOTAL_W'(load_count) + TOTAL_W'(1) == total) begin
            load_count_next = '0;
            row_next        = '0;
            col_next        = '0;
            tap_next        = '0;
            a_base_next     = '0;
            b_base_next     = '0;
            state_next      = ST_ISSUE;
          end else begin
            load_count_next = load_count + COUNT_W'(1);
          end
        end
      end
      ST_ISSUE: begin
        cmd.rd       = 1'b1;
        cmd.first    = (tap == '0);
        cmd.last_tap = (tap == IDX_W'(k - 1'b1));
        if (cmd.last_tap) begin
          tap_next   = '0;
          state_next = ST_DRAIN;
        end else begin
          tap_next = tap + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (stat.acc_done && stat.out_free) begin
          cmd.emit = 1'b1;
          if (row == IDX_W'(m - 1'b1)) begin
            row_next    = '0;
            a_base_next = '0;
            if (col == IDX_W'(n - 1'b1)) begin
              col_next    = '0;
              b_base_next = '0;
              state_next  = ST_LOAD;
            end else begin
              col_next    = col + IDX_W'(1);
              b_base_next = b_base + ADDR_W'(k);
              state_next  = ST_ISSUE;
            end
          end else begin
            row_next    = row + IDX_W'(1);
            a_base_next = a_base + ADDR_W'(k);
            state_next  = ST_ISSUE;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase

    if (cfg_we && (cfg_index == REG_ROWS_M || cfg_index == REG_COLS_N ||
                   cfg_index == REG_INNER_K)) begin
      load_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      rows_m     <= DIM_W'(1);
      cols_n     <= DIM_W'(1);
      inner_k    <= DIM_W'(1);
      load_count <= '0;
      row        <= '0;
      col        <= '0;
      tap        <= '0;
      a_base     <= '0;
      b_base     <= '0;
    end else begin
      state      <= state_next;
      load_count <= load_count_next;
      row        <= row_next;
      col        <= col_next;
      tap        <= tap_next;
      a_base     <= a_base_next;
      b_base     <= b_base_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ROWS_M:  rows_m  <= cfg_data;
          REG_COLS_N:  cols_n  <= cfg_data;
          REG_INNER_K: inner_k <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

endmodule

/* rtl/tmm_datapath.sv */
// Datapath: A and B element memories, multiply-accumulate pipeline and result register.
`timescale 1ns / 1ps

module tmm_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  tmm_pkg::cmd_t                         cmd,
  output tmm_pkg::stat_t                        stat,
  input  logic signed [tmm_pkg::DATA_WIDTH-1:0] element,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [tmm_pkg::DATA_WIDTH-1:0] product,
  output logic [tmm_pkg::IDX_W-1:0]             row_index,
  output logic [tmm_pkg::IDX_W-1:0]             col_index,
  output logic                                  saturated,
  output logic                                  last
);
  import tmm_pkg::*;

  logic [DATA_WIDTH-1:0]     a_mem [DEPTH];
  logic [DATA_WIDTH-1:0]     b_mem [DEPTH];
  logic signed [DATA_WIDTH-1:0] a_rd, b_rd;
  logic                      rd_valid, rd_first, rd_last;
  logic signed [PROD_W-1:0]  mul;
  logic                      mul_valid, mul_first, mul_last;
  logic signed [ACC_W-1:0]   acc;
  logic                      acc_done;

  logic [ACC_W-DATA_WIDTH-FRAC_BITS:0] upper;
  logic                                in_range;
  logic signed [DATA_WIDTH-1:0]        clipped;

  always_ff @(posedge clk) begin
    if (cmd.wr_a) begin
      a_mem[cmd.wr_addr] <= element;
    end
    if (cmd.wr_b) begin
      b_mem[cmd.wr_addr] <= element;
    end
    a_rd <= a_mem[cmd.rd_a_addr];
    b_rd <= b_mem[cmd.rd_b_addr];
  end

  always_ff @(posedge clk) begin
    rd_first  <= cmd.first;
    rd_last   <= cmd.last_tap;
    mul       <= a_rd * b_rd;
    mul_first <= rd_first;
    mul_last  <= rd_last;
    if (mul_valid) begin
      if (mul_first) begin
        acc <= ACC_W'(mul);
      end else begin
        acc <= acc + ACC_W'(mul);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid  <= 1'b0;
      mul_valid <= 1'b0;
      acc_done  <= 1'b0;
    end else begin
      rd_valid  <= cmd.rd;
      mul_valid <= rd_valid;
      if (mul_valid && mul_last) begin
        acc_done <= 1'b1;
      end else if (cmd.emit) begin
        acc_done <= 1'b0;
      end
    end
  end

  assign upper    = acc[ACC_W-1:FRAC_BITS+DATA_WIDTH-1];
  assign in_range = (&upper) || !(|upper);
  assign clipped  = acc[ACC_W-1] ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                                 : {1'b0, {(DATA_WIDTH-1){1'b1}}};

  assign stat.acc_done = acc_done;
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      product   <= in_range ? acc[FRAC_BITS+DATA_WIDTH-1:FRAC_BITS] : clipped;
      saturated <= !in_range;
      row_index <= cmd.row;
      col_index <= cmd.col;
      last      <= cmd.last_entry;
    end
  end

endmodule

/* rtl/transposed_matrix_multiply_top.sv */
// Top level of the transposed matrix multiply C = A' * B in signed Q16.16.
//
//  Channel  Handshake             Payload
//  config   cfg_we                cfg_index, cfg_data
//  input    in_valid / in_ready   element
//  output   out_valid / out_ready product, row_index, col_index, saturated, last
//
// While loading, each element word is accepted in the same cycle in_valid is high.
// The word that completes B starts the compute phase: the result entries are
// computed one at a time on the single multiply-accumulate unit, so a full load
// of m*k + k*n words is followed by all m*n results before the input is ready
// again. A stalled output holds the sequencer before the next entry is emitted.
// Reset is synchronous and sets all three sizes to one with an empty load.
`timescale 1ns / 1ps

module transposed_matrix_multiply_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [tmm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [tmm_pkg::DIM_W-1:0]             cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [tmm_pkg::DATA_WIDTH-1:0] element,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [tmm_pkg::DATA_WIDTH-1:0] product,
  output logic [tmm_pkg::IDX_W-1:0]             row_index,
  output logic [tmm_pkg::IDX_W-1:0]             col_index,
  output logic                                  saturated,
  output logic                                  last
);
  import tmm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  tmm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tmm_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .element   (element),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .product   (product),
    .row_index (row_index),
    .col_index (col_index),
    .saturated (saturated),
    .last      (last)
  );

endmodule
